// File: rtl/ca_pkg.sv
// Shared constants for the classification accuracy block.
`default_nettype none
package ca_pkg;
	localparam int NUM_CLASSES_W   = 5;
	localparam int VALUE_W         = 16;
	localparam int ACC_W           = 17;
	localparam int OUT_CNT_W       = 20;
	localparam int FRAC_BITS       = 16;
	localparam int DEF_MAX_CLASSES = 16;
	localparam int DEF_COUNT_BITS  = 20;

	// 0.5 and 1.0 in signed Q8.8.
	localparam logic signed [VALUE_W-1:0] HALF_Q88 = 16'sd128;
	localparam logic signed [VALUE_W-1:0] ONE_Q88  = 16'sd256;
	localparam logic signed [VALUE_W-1:0] ZERO_Q88 = 16'sd0;
endpackage
`default_nettype wire

// File: rtl/ca_if.sv
// Request channels for sample elements and for accuracy results.
`default_nettype none
interface ca_in_if import ca_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] pred_value;
	logic signed [VALUE_W-1:0] true_value;
	logic                      last;

	modport source (output valid, pred_value, true_value, last, input ready);
	modport sink (input valid, pred_value, true_value, last, output ready);
endinterface

interface ca_out_if import ca_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [ACC_W-1:0]     accuracy;
	logic [OUT_CNT_W-1:0] right_rows;
	logic [OUT_CNT_W-1:0] total_rows;

	modport source (output valid, accuracy, right_rows, total_rows, input ready);
	modport sink (input valid, accuracy, right_rows, total_rows, output ready);
endinterface
`default_nettype wire

// File: rtl/ca_front.sv
// Front end: judges each row and keeps the saturating right and total counts.
`default_nettype none
module ca_front import ca_pkg::*; #(
	parameter int MAX_CLASSES = DEF_MAX_CLASSES,
	parameter int COUNT_BITS  = DEF_COUNT_BITS
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	ca_in_if.sink                         samples,
	input  wire logic [NUM_CLASSES_W-1:0] num_classes,
	output      logic                     push_valid,
	input  wire logic                     push_ready,
	output      logic [COUNT_BITS-1:0]    push_right,
	output      logic [COUNT_BITS-1:0]    push_rows
);
	localparam int IDX_W = $clog2(MAX_CLASSES);
	localparam int CMP_W = ((IDX_W > NUM_CLASSES_W) ? IDX_W : NUM_CLASSES_W) + 1;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

	logic [IDX_W-1:0]          col_q;
	logic signed [VALUE_W-1:0] best_pred_q;
	logic signed [VALUE_W-1:0] best_true_q;
	logic [IDX_W-1:0]          best_pred_idx_q;
	logic [IDX_W-1:0]          best_true_idx_q;
	logic [COUNT_BITS-1:0]     right_q;
	logic [COUNT_BITS-1:0]     rows_q;

	logic [CMP_W-1:0]          n_raw;
	logic [CMP_W-1:0]          n_eff;
	logic [CMP_W-1:0]          n_last;
	logic                      binary;
	logic                      wrong;
	logic                      accept;
	logic signed [VALUE_W-1:0] best_pred_n;
	logic signed [VALUE_W-1:0] best_true_n;
	logic [IDX_W-1:0]          best_pred_idx_n;
	logic [IDX_W-1:0]          best_true_idx_n;
	logic                      row_done;
	logic                      row_right;
	logic [COUNT_BITS-1:0]     rows_n;
	logic [COUNT_BITS-1:0]     right_n;

	assign accept        = samples.valid && samples.ready;
	assign samples.ready = push_ready;

	always_comb begin
		n_raw = CMP_W'(num_classes);
		if (n_raw == '0) begin
			n_eff = CMP_W'(1);
		end else if (n_raw > CMP_W'(MAX_CLASSES)) begin
			n_eff = CMP_W'(MAX_CLASSES);
		end else begin
			n_eff = n_raw;
		end
		n_last = n_eff - CMP_W'(1);
		binary = (n_eff == CMP_W'(1));
	end

	assign wrong = ((samples.pred_value < HALF_Q88) && (samples.true_value == ONE_Q88)) ||
		((samples.pred_value >= HALF_Q88) && (samples.true_value == ZERO_Q88));

	always_comb begin
		best_pred_n     = best_pred_q;
		best_true_n     = best_true_q;
		best_pred_idx_n = best_pred_idx_q;
		best_true_idx_n = best_true_idx_q;
		if (col_q == '0) begin
			best_pred_n     = samples.pred_value;
			best_true_n     = samples.true_value;
			best_pred_idx_n = '0;
			best_true_idx_n = '0;
		end else begin
			// Strict compare keeps the first maximum on ties.
			if (samples.pred_value > best_pred_q) begin
				best_pred_n     = samples.pred_value;
				best_pred_idx_n = col_q;
			end
			if (samples.true_value > best_true_q) begin
				best_true_n     = samples.true_value;
				best_true_idx_n = col_q;
			end
		end
	end

	always_comb begin
		row_done  = binary || (CMP_W'(col_q) >= n_last);
		row_right = binary ? !wrong : (best_pred_idx_n == best_true_idx_n);
		rows_n    = rows_q;
		right_n   = right_q;
		if (row_done) begin
			if (rows_q != CNT_MAX) begin
				rows_n = rows_q + COUNT_BITS'(1);
			end
			if (row_right && (right_q != CNT_MAX)) begin
				right_n = right_q + COUNT_BITS'(1);
			end
		end
	end

	assign push_valid = accept && samples.last;
	assign push_right = right_n;
	assign push_rows  = rows_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q           <= '0;
			best_pred_q     <= '0;
			best_true_q     <= '0;
			best_pred_idx_q <= '0;
			best_true_idx_q <= '0;
			right_q         <= '0;
			rows_q          <= '0;
		end else if (accept) begin
			if (samples.last) begin
				col_q           <= '0;
				best_pred_q     <= '0;
				best_true_q     <= '0;
				best_pred_idx_q <= '0;
				best_true_idx_q <= '0;
				right_q         <= '0;
				rows_q          <= '0;
			end else begin
				right_q <= right_n;
				rows_q  <= rows_n;
				if (!binary) begin
					best_pred_q     <= best_pred_n;
					best_true_q     <= best_true_n;
					best_pred_idx_q <= best_pred_idx_n;
					best_true_idx_q <= best_true_idx_n;
					col_q           <= row_done ? '0 : col_q + IDX_W'(1);
				end
			end
		end
	end
endmodule
`default_nettype wire

// File: rtl/ca_fifo.sv
// Two-entry queue that carries finished counts from the front end to the divider.
`default_nettype none
module ca_fifo #(
	parameter int WIDTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push_valid,
	output      logic             push_ready,
	input  wire logic [WIDTH-1:0] push_data,
	output      logic             pop_valid,
	input  wire logic             pop_ready,
	output      logic [WIDTH-1:0] pop_data
);
	logic [WIDTH-1:0] entry_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       fill_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (fill_q != 2'd2);
	assign pop_valid  = (fill_q != 2'd0);
	assign pop_data   = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end
endmodule
`default_nettype wire

// File: rtl/ca_back.sv
// Back end: shift-subtract divider for the Q1.16 ratio and the result register.
`default_nettype none
module ca_back import ca_pkg::*; #(
	parameter int COUNT_BITS = DEF_COUNT_BITS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  pop_valid,
	output      logic                  pop_ready,
	input  wire logic [COUNT_BITS-1:0] pop_right,
	input  wire logic [COUNT_BITS-1:0] pop_rows,
	ca_out_if.source                   result
);
	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_DIV  = 1'b1;
	localparam int   STEP_W  = $clog2(FRAC_BITS + 1);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(FRAC_BITS);

	logic                  state_q;
	logic [STEP_W-1:0]     step_q;
	logic [COUNT_BITS:0]   rem_q;
	logic [COUNT_BITS-1:0] divisor_q;
	logic [COUNT_BITS-1:0] right_q;
	logic [FRAC_BITS-1:0]  quot_q;
	logic                  out_valid_q;
	logic [ACC_W-1:0]      acc_q;
	logic [COUNT_BITS-1:0] out_right_q;
	logic [COUNT_BITS-1:0] out_rows_q;

	logic [COUNT_BITS:0]   trial;
	logic                  q_bit;
	logic [COUNT_BITS:0]   rem_n;

	assign pop_ready = (state_q == ST_IDLE) && !out_valid_q;

	// The first step tests the integer bit without a shift; the remainder stays
	// below the divisor afterwards, so the doubled value fits one extra bit.
	always_comb begin
		trial = (step_q == '0) ? rem_q : {rem_q[COUNT_BITS-1:0], 1'b0};
		q_bit = (trial >= {1'b0, divisor_q});
		rem_n = q_bit ? (trial - {1'b0, divisor_q}) : trial;
	end

	always_ff @(posedge clk) begin
		if (pop_valid && pop_ready) begin
			rem_q     <= {1'b0, pop_right};
			divisor_q <= pop_rows;
			right_q   <= pop_right;
		end else if (state_q == ST_DIV) begin
			rem_q  <= rem_n;
			quot_q <= {quot_q[FRAC_BITS-2:0], q_bit};
		end
		if ((state_q == ST_DIV) && (step_q == LAST_STEP)) begin
			acc_q       <= (divisor_q == '0) ? '0 : {quot_q, q_bit};
			out_right_q <= right_q;
			out_rows_q  <= divisor_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (result.valid && result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop_valid && pop_ready) begin
						state_q <= ST_DIV;
						step_q  <= '0;
					end
				end
				ST_DIV: begin
					if (step_q == LAST_STEP) begin
						state_q     <= ST_IDLE;
						out_valid_q <= 1'b1;
					end else begin
						step_q <= step_q + STEP_W'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result.valid      = out_valid_q;
	assign result.accuracy   = acc_q;
	assign result.right_rows = OUT_CNT_W'(out_right_q);
	assign result.total_rows = OUT_CNT_W'(out_rows_q);
endmodule
`default_nettype wire

// File: rtl/classification_accuracy.sv
// Classification accuracy: streams prediction/truth pairs one per cycle, row by
// row with num_classes columns (1 selects 0.5 thresholding), counts right and
// total rows with saturation, and on the item flagged last reports both counts
// and their floored Q1.16 ratio. Samples are taken at one per cycle; the input
// stalls only while two finished data sets wait in the two-entry queue ahead of
// the divider. A result goes from its last item into the queue and then through
// the one-bit-per-cycle shift-subtract divider, plus any wait for an earlier
// result to be taken. Write num_classes only while no data set is in progress;
// it resets to 1. There is no clearing pass after reset.
`default_nettype none
module classification_accuracy import ca_pkg::*; #(
	parameter int MAX_CLASSES = DEF_MAX_CLASSES,
	parameter int COUNT_BITS  = DEF_COUNT_BITS
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_we,
	input  wire logic [NUM_CLASSES_W-1:0] cfg_data,
	ca_in_if.sink                         samples,
	ca_out_if.source                      result
);
	logic [NUM_CLASSES_W-1:0] num_classes_q;
	logic                     q_push_valid;
	logic                     q_push_ready;
	logic [COUNT_BITS-1:0]    q_push_right;
	logic [COUNT_BITS-1:0]    q_push_rows;
	logic                     q_pop_valid;
	logic                     q_pop_ready;
	logic [2*COUNT_BITS-1:0]  q_pop_data;
	logic [COUNT_BITS-1:0]    q_pop_right;
	logic [COUNT_BITS-1:0]    q_pop_rows;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_classes_q <= NUM_CLASSES_W'(1);
		end else if (cfg_we) begin
			num_classes_q <= cfg_data;
		end
	end

	ca_front #(
		.MAX_CLASSES(MAX_CLASSES),
		.COUNT_BITS (COUNT_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.samples    (samples),
		.num_classes(num_classes_q),
		.push_valid (q_push_valid),
		.push_ready (q_push_ready),
		.push_right (q_push_right),
		.push_rows  (q_push_rows)
	);

	ca_fifo #(
		.WIDTH(2 * COUNT_BITS)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(q_push_valid),
		.push_ready(q_push_ready),
		.push_data ({q_push_right, q_push_rows}),
		.pop_valid (q_pop_valid),
		.pop_ready (q_pop_ready),
		.pop_data  (q_pop_data)
	);

	assign q_pop_right = q_pop_data[2*COUNT_BITS-1:COUNT_BITS];
	assign q_pop_rows  = q_pop_data[COUNT_BITS-1:0];

	ca_back #(
		.COUNT_BITS(COUNT_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop_valid(q_pop_valid),
		.pop_ready(q_pop_ready),
		.pop_right(q_pop_right),
		.pop_rows (q_pop_rows),
		.result   (result)
	);

	// A queued data set can never have more right rows than rows.
	a_right_le_rows: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop_valid |-> (q_pop_right <= q_pop_rows))
		else $error("queued right count exceeds row count");

	// The ratio never goes above 1.0.
	a_acc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.accuracy <= ACC_W'(65536)))
		else $error("accuracy above 1.0");

	// The front end only finishes a data set when the queue has room for it.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push_valid |-> q_push_ready)
		else $error("finished counts pushed into a full queue");
endmodule
`default_nettype wire

// File: test/ca_accuracy_checker.sv
// Checker for the accuracy block: predicts each data set tally and compares results in order.
module ca_accuracy_checker import ca_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_we,
	input  wire logic [NUM_CLASSES_W-1:0] cfg_data,
	ca_in_if                              samples,
	ca_out_if                             result,
	output int                            fail_count,
	output int                            pending
);
	localparam int COL_W = $clog2(DEF_MAX_CLASSES);
	localparam logic [OUT_CNT_W-1:0] COUNT_CEIL = '1;

	typedef struct packed {
		logic [ACC_W-1:0]     accuracy;
		logic [OUT_CNT_W-1:0] right_rows;
		logic [OUT_CNT_W-1:0] total_rows;
	} tally_t;

	logic [NUM_CLASSES_W-1:0]  class_setting;
	logic [COL_W-1:0]          col_pos;
	logic signed [VALUE_W-1:0] lead_pred;
	logic signed [VALUE_W-1:0] lead_true;
	logic [COL_W-1:0]          lead_pred_col;
	logic [COL_W-1:0]          lead_true_col;
	logic [OUT_CNT_W-1:0]      right_cnt;
	logic [OUT_CNT_W-1:0]      row_cnt;
	tally_t                    expected_tallies[$];

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $time, msg);
		fail_count++;
	endtask

	task automatic clear_row_state();
		col_pos       = '0;
		lead_pred     = '0;
		lead_true     = '0;
		lead_pred_col = '0;
		lead_true_col = '0;
	endtask

	task automatic absorb_sample(input logic signed [VALUE_W-1:0] p,
			input logic signed [VALUE_W-1:0] t, input logic lst);
		logic [NUM_CLASSES_W-1:0]           cols;
		logic                               row_done;
		logic                               row_right;
		logic [OUT_CNT_W+FRAC_BITS-1:0]     scaled;
		tally_t                             due;
		cols = class_setting;
		if (cols == 0)
			cols = 1;
		if (cols > DEF_MAX_CLASSES)
			cols = DEF_MAX_CLASSES;
		row_done  = 1'b0;
		row_right = 1'b0;
		if (cols == 1) begin
			row_done  = 1'b1;
			row_right = !((p < HALF_Q88 && t == ONE_Q88) || (p >= HALF_Q88 && t == ZERO_Q88));
		end else begin
			// The first column seeds both maxima; later columns win only when strictly larger.
			if (col_pos == 0) begin
				lead_pred     = p;
				lead_pred_col = '0;
				lead_true     = t;
				lead_true_col = '0;
			end else begin
				if (p > lead_pred) begin
					lead_pred     = p;
					lead_pred_col = col_pos;
				end
				if (t > lead_true) begin
					lead_true     = t;
					lead_true_col = col_pos;
				end
			end
			if (col_pos >= cols - 1) begin
				row_done  = 1'b1;
				row_right = (lead_pred_col == lead_true_col);
				col_pos   = '0;
			end else begin
				col_pos = col_pos + 1'b1;
			end
		end
		if (row_done) begin
			if (row_cnt != COUNT_CEIL)
				row_cnt++;
			if (row_right && right_cnt != COUNT_CEIL)
				right_cnt++;
		end
		if (lst) begin
			scaled       = {right_cnt, {FRAC_BITS{1'b0}}};
			due.accuracy = (row_cnt == 0) ? '0 : ACC_W'(scaled / row_cnt);
			due.right_rows = right_cnt;
			due.total_rows = row_cnt;
			expected_tallies.push_back(due);
			clear_row_state();
			right_cnt = '0;
			row_cnt   = '0;
		end
	endtask

	task automatic match_tally(input tally_t got);
		tally_t want;
		if (expected_tallies.size() == 0) begin
			report_mismatch($sformatf("unexpected result accuracy=%0d right=%0d total=%0d",
				got.accuracy, got.right_rows, got.total_rows));
			return;
		end
		want = expected_tallies.pop_front();
		if (got.accuracy !== want.accuracy)
			report_mismatch($sformatf("accuracy %0d, expected %0d", got.accuracy, want.accuracy));
		if (got.right_rows !== want.right_rows)
			report_mismatch($sformatf("right_rows %0d, expected %0d",
				got.right_rows, want.right_rows));
		if (got.total_rows !== want.total_rows)
			report_mismatch($sformatf("total_rows %0d, expected %0d",
				got.total_rows, want.total_rows));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			class_setting = 5'd1;
			clear_row_state();
			right_cnt = '0;
			row_cnt   = '0;
			expected_tallies.delete();
			fail_count = 0;
			pending    = 0;
		end else begin
			if (result.valid && result.ready)
				match_tally('{result.accuracy, result.right_rows, result.total_rows});
			if (samples.valid && samples.ready)
				absorb_sample(samples.pred_value, samples.true_value, samples.last);
			// A register write only affects requests accepted after this edge.
			if (cfg_we)
				class_setting = cfg_data;
			pending = expected_tallies.size();
		end
	end
endmodule

// File: test/classification_accuracy_tb.sv
// Top of the accuracy testbench: clock, reset, request traffic, register writes and verdict.
module classification_accuracy_tb;
	import ca_pkg::*;

	localparam int CYCLE_LIMIT    = 100_000;
	localparam int SETTLE_CYCLES  = 40;
	localparam int HOLD_CYCLES    = 300;
	localparam int RANDOM_ITEMS   = 550;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     cfg_we;
	logic [NUM_CLASSES_W-1:0] cfg_data;
	int                       fail_count;
	int                       pending;
	int                       items_sent = 0;
	int                       hold_requests = 0;
	int                       holds_done = 0;
	int                       cycle_count = 0;
	bit                       gaps_on = 1'b1;

	ca_in_if  samples_if ();
	ca_out_if result_if ();

	classification_accuracy DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.samples  (samples_if),
		.result   (result_if)
	);

	ca_accuracy_checker accuracy_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.samples    (samples_if),
		.result     (result_if),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	// Corner values around the 0.5 threshold and the range ends, a few coarse
	// levels that make ties common, and otherwise any 16-bit value.
	function automatic logic [VALUE_W-1:0] pick_score();
		logic [VALUE_W-1:0] v;
		case ($urandom_range(0, 15))
			0: v = 16'h8000;
			1: v = 16'hFFFF;
			2: v = 16'h0000;
			3: v = 16'h007F;
			4: v = 16'h0080;
			5: v = 16'h0081;
			6: v = 16'h0100;
			7: v = 16'h7FFF;
			8, 9, 10: v = VALUE_W'($urandom_range(0, 3) * 64);
			default: v = VALUE_W'($urandom);
		endcase
		return v;
	endfunction

	task automatic offer_sample(input logic [VALUE_W-1:0] p, input logic [VALUE_W-1:0] t,
			input logic lst);
		int gap;
		gap = gaps_on ? pick_gap() : 0;
		if (gap > 0) begin
			samples_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		samples_if.valid      <= 1'b1;
		samples_if.pred_value <= p;
		samples_if.true_value <= t;
		samples_if.last       <= lst;
		@(posedge clk);
		while (!samples_if.ready)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic finish_burst();
		samples_if.valid <= 1'b0;
		@(posedge clk);
	endtask

	// The block must be idle for a register write, so every result is drained first.
	task automatic set_classes(input int setting);
		wait (pending == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= setting[NUM_CLASSES_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_data_set(input int cols, input int max_rows);
		int rows;
		int tail;
		int total;
		rows = $urandom_range((cols == 1) ? 1 : 0, max_rows);
		tail = 0;
		if (cols > 1 && ($urandom_range(0, 5) == 0 || rows == 0))
			tail = $urandom_range(1, cols - 1);
		total = rows * cols + tail;
		for (int k = 0; k < total; k++)
			offer_sample(pick_score(), pick_score(), k == total - 1);
	endtask

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	initial begin : result_drain
		int run;
		result_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (holds_done < hold_requests) begin
				holds_done++;
				result_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				run = $urandom_range(0, 99);
				if (run < 60) begin
					result_if.ready <= 1'b1;
					repeat ($urandom_range(1, 20)) @(posedge clk);
				end else begin
					result_if.ready <= 1'b0;
					repeat (pick_gap() + 1) @(posedge clk);
				end
			end
		end
	end

	initial begin : stimulus
		int base;
		int phase;
		int setting;
		int eff;
		arst_n                <= 1'b0;
		cfg_we                <= 1'b0;
		cfg_data              <= '0;
		samples_if.valid      <= 1'b0;
		samples_if.pred_value <= '0;
		samples_if.true_value <= '0;
		samples_if.last       <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Binary mode straight out of reset: both sides of the threshold against
		// truths of one, zero and other values.
		offer_sample(16'h007F, 16'h0100, 1'b0);
		offer_sample(16'h0080, 16'h0100, 1'b0);
		offer_sample(16'h0080, 16'h0000, 1'b0);
		offer_sample(16'h007F, 16'h0000, 1'b0);
		offer_sample(16'h8000, 16'h7FFF, 1'b0);
		offer_sample(16'h7FFF, 16'h8000, 1'b0);
		offer_sample(16'h7FFF, 16'h0100, 1'b1);
		finish_burst();

		// Three classes: a full tie, an argmax mismatch, then a partial row that
		// must be dropped; afterwards a data set with no complete row at all.
		set_classes(3);
		repeat (3) offer_sample(16'h0005, 16'h0005, 1'b0);
		offer_sample(16'h0001, 16'h0009, 1'b0);
		offer_sample(16'h0009, 16'h0001, 1'b0);
		offer_sample(16'h0003, 16'h0003, 1'b0);
		offer_sample(16'h0000, 16'h0000, 1'b0);
		offer_sample(16'h0000, 16'h0000, 1'b1);
		finish_burst();
		offer_sample(16'h0000, 16'h0000, 1'b1);
		finish_burst();

		base  = items_sent;
		phase = 0;
		while (items_sent - base < RANDOM_ITEMS) begin
			case (phase)
				0: setting = 0;
				1: setting = 16;
				2: setting = 2;
				3: setting = 31;
				4: setting = 17;
				5: setting = 1;
				6: setting = 1;
				default: setting = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 4)
					: $urandom_range(0, 31);
			endcase
			set_classes(setting);
			eff = (setting == 0) ? 1 : (setting > DEF_MAX_CLASSES) ? DEF_MAX_CLASSES : setting;
			if (phase == 6) begin
				// Hold the result side long enough that finished data sets pile up
				// and the block has to refuse further requests.
				hold_requests++;
				wait (holds_done == hold_requests);
				gaps_on = 1'b0;
				repeat (8) send_data_set(eff, 1);
			end else begin
				gaps_on = ($urandom_range(0, 3) != 0);
				repeat ($urandom_range(1, 4))
					send_data_set(eff, (eff > 4) ? 2 : 8);
			end
			finish_burst();
			phase++;
		end

		wait (pending == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
